### hw/rtl/sfcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame CRC checker package
// Header codes, byte positions and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package sfcc_pkg;

    localparam int unsigned POS_W = 17;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [15:0]      t_word;
    typedef logic [7:0]       t_byte;

    localparam t_byte SYNC0_CODE = 8'h5A;
    localparam t_byte SYNC1_CODE = 8'hA5;
    localparam t_word CRC_POLY   = 16'h1021;
    localparam t_word CRC_TOP    = 16'h8000;

    // Byte positions inside a frame.
    localparam t_pos POS_SYNC0  = 17'd0;
    localparam t_pos POS_SYNC1  = 17'd1;
    localparam t_pos POS_LEN_LO = 17'd2;
    localparam t_pos POS_LEN_HI = 17'd3;
    localparam t_pos POS_CRC_LO = 17'd4;
    localparam t_pos POS_CRC_HI = 17'd5;

    // CRC-16, MSB first, one whole byte per call.
    function automatic t_word crc_byte(input t_word crc, input t_byte b);
        t_word c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/sfcc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame CRC checker channels
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface sfcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcc_out_if;
    logic        valid;
    logic        ready;
    logic        crc_match;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic [15:0] frame_payload_length;

    modport source (output valid, output crc_match, output computed_crc,
                    output received_crc, output frame_payload_length, input ready);
    modport sink   (input valid, input crc_match, input computed_crc,
                    input received_crc, input frame_payload_length, output ready);
endinterface
`default_nettype wire

### hw/rtl/sensor_frame_crc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame CRC checker
// Parses framed bytes (sync 5A A5, length, CRC, payload) and checks CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one received byte per request, with frame_start marking the
//   first byte of a buffer. o_res carries one request per complete frame:
//   the match flag, the computed CRC, the CRC found in the frame and the
//   payload length. Frames with a bad sync pair and stray bytes give nothing.
//   A byte is registered on acceptance and processed against the frame state
//   once the output register is free, and a result is registered in the
//   output register when the frame's last byte is processed. One byte per
//   cycle is sustained while the receiver does not stall; the CRC update of
//   a whole byte is combinational. When the receiver stalls, the result
//   stays in the output register and the input register holds at most one
//   more byte; after that i_in ready drops until the result is taken.
//   Reset clears the frame state and the valid flags of both registers; the
//   first byte after reset needs frame_start to open a frame.
// ----------------------------------------------------------------------------
module sensor_frame_crc_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sfcc_in_if.sink    i_in,
    sfcc_out_if.source o_res
);
    import sfcc_pkg::*;

    // Input register.
    logic  r_in_valid;
    t_byte r_byte;
    logic  r_start;

    // Frame state.
    logic  r_active, n_active;
    t_pos  r_pos, n_pos;
    t_word r_len, n_len;
    t_word r_rcrc, n_rcrc;
    t_word r_crc, n_crc;

    // Result register.
    logic  r_out_valid;
    logic  r_match;
    t_word r_out_ccrc;
    t_word r_out_rcrc;
    t_word r_out_len;

    logic  out_free;
    logic  proc_fire;
    logic  emit;
    t_word crc_upd;
    t_word base_crc;
    t_pos  end_pos;

    assign out_free  = !r_out_valid || o_res.ready;
    assign proc_fire = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte  <= i_in.rx_byte;
            r_start <= i_in.frame_start;
        end
    end

    // A start restarts the CRC from zero, so the update works from either base.
    assign base_crc = r_start ? 16'h0000 : r_crc;
    assign crc_upd  = crc_byte(base_crc, r_byte);
    assign end_pos  = t_pos'(17'd5 + {1'b0, r_len});

    always_comb begin
        n_active = r_active;
        n_pos    = r_pos;
        n_len    = r_len;
        n_rcrc   = r_rcrc;
        n_crc    = r_crc;
        emit     = 1'b0;
        if (proc_fire) begin
            if (r_start) begin
                n_active = 1'b1;
                n_pos    = POS_SYNC0;
                n_len    = 16'h0000;
                n_rcrc   = 16'h0000;
                n_crc    = 16'h0000;
            end
            if (r_start || r_active) begin
                n_pos = t_pos'((r_start ? POS_SYNC0 : r_pos) + 17'd1);
                unique case (r_start ? POS_SYNC0 : r_pos)
                    POS_SYNC0: begin
                        if (r_byte != SYNC0_CODE) begin
                            n_active = 1'b0;
                        end
                        n_crc = crc_upd;
                    end
                    POS_SYNC1: begin
                        if (r_byte != SYNC1_CODE) begin
                            n_active = 1'b0;
                        end
                        n_crc = crc_upd;
                    end
                    POS_LEN_LO: begin
                        n_len = {r_len[15:8], r_byte};
                        n_crc = crc_upd;
                    end
                    POS_LEN_HI: begin
                        n_len = {r_byte, r_len[7:0]};
                        n_crc = crc_upd;
                    end
                    POS_CRC_LO: begin
                        n_rcrc = {r_rcrc[15:8], r_byte};
                    end
                    POS_CRC_HI: begin
                        n_rcrc = {r_byte, r_rcrc[7:0]};
                        emit   = (r_len == 16'h0000);
                    end
                    default: begin
                        n_crc = crc_upd;
                        emit  = (r_pos >= end_pos);
                    end
                endcase
                if (emit) begin
                    n_active = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
            r_len    <= '0;
            r_rcrc   <= '0;
            r_crc    <= '0;
        end else begin
            r_active <= n_active;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_rcrc   <= n_rcrc;
            r_crc    <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc_fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && emit) begin
            r_match    <= (n_crc == n_rcrc);
            r_out_ccrc <= n_crc;
            r_out_rcrc <= n_rcrc;
            r_out_len  <= n_len;
        end
    end

    assign o_res.valid                = r_out_valid;
    assign o_res.crc_match            = r_match;
    assign o_res.computed_crc         = r_out_ccrc;
    assign o_res.received_crc         = r_out_rcrc;
    assign o_res.frame_payload_length = r_out_len;

    // A result always closes the frame.
    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && emit) |=> !r_active)
        else $error("frame still active after a result");

    // An empty output register never holds back the input side.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty output register");

    // The match flag agrees with the two CRCs it reports.
    a_match_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_match == (r_out_ccrc == r_out_rcrc)))
        else $error("match flag disagrees with reported CRCs");

    // Bytes without an open frame never produce a result.
    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && !r_start && !r_active) |-> !emit)
        else $error("result from a byte outside a frame");

endmodule
`default_nettype wire

### tb/sfcc_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame CRC checker - frame parser model and result checker
// Follows every accepted byte with its own copy of the frame parser and the
// CRC-16, queues the frame result that each complete frame should produce,
// and compares every accepted result with the oldest queued one.
// ----------------------------------------------------------------------------
module sfcc_frame_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    sfcc_in_if   i_bytes,
    sfcc_out_if  i_frames,
    output int   o_fail_count,
    output int   o_pending
);
    import sfcc_pkg::*;

    typedef struct packed {
        logic  crc_match;
        t_word computed_crc;
        t_word received_crc;
        t_word pay_length;
    } t_frame_result;

    t_frame_result expected_frames[$];
    int            fail_count = 0;

    // Parser state.
    t_pos  frame_pos;
    logic  in_frame;
    t_word frame_len;
    t_word crc_in_frame;
    t_word crc_acc;

    assign o_fail_count = fail_count;

    // Bit-serial form: feed the message bit into the top of the register.
    function automatic t_word crc_step(input t_word crc, input t_byte b);
        t_word c;
        logic  fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void compare_field(input string name, input t_word want,
                                          input t_word got);
        if (want !== got) begin
            $error("%s: expected 0x%04h, got 0x%04h", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic parse_byte(input t_byte b, input logic start);
        logic          done;
        t_frame_result r;
        done = 1'b0;
        if (start) begin
            frame_pos    = '0;
            in_frame     = 1'b1;
            crc_acc      = '0;
            frame_len    = '0;
            crc_in_frame = '0;
        end
        if (in_frame) begin
            case (frame_pos)
                POS_SYNC0: begin
                    if (b != SYNC0_CODE) in_frame = 1'b0;
                    else crc_acc = crc_step(crc_acc, b);
                end
                POS_SYNC1: begin
                    if (b != SYNC1_CODE) in_frame = 1'b0;
                    else crc_acc = crc_step(crc_acc, b);
                end
                POS_LEN_LO: begin
                    frame_len[7:0] = b;
                    crc_acc = crc_step(crc_acc, b);
                end
                POS_LEN_HI: begin
                    frame_len[15:8] = b;
                    crc_acc = crc_step(crc_acc, b);
                end
                POS_CRC_LO: begin
                    crc_in_frame[7:0] = b;
                end
                POS_CRC_HI: begin
                    crc_in_frame[15:8] = b;
                    done = (frame_len == 16'h0000);
                end
                default: begin
                    crc_acc = crc_step(crc_acc, b);
                    done = (frame_pos >= POS_CRC_HI + t_pos'(frame_len));
                end
            endcase
            if (in_frame) begin
                frame_pos = t_pos'(frame_pos + 17'd1);
            end
            if (done) begin
                in_frame       = 1'b0;
                r.crc_match    = (crc_acc == crc_in_frame);
                r.computed_crc = crc_acc;
                r.received_crc = crc_in_frame;
                r.pay_length   = frame_len;
                expected_frames.push_back(r);
            end
        end
    endtask

    task automatic check_frame_result();
        t_frame_result want;
        if (expected_frames.size() == 0) begin
            $error("result request with no frame pending: match %b crc 0x%04h",
                   i_frames.crc_match, i_frames.computed_crc);
            fail_count++;
        end else begin
            want = expected_frames.pop_front();
            compare_field("crc_match", {15'h0, want.crc_match},
                          {15'h0, i_frames.crc_match});
            compare_field("computed_crc", want.computed_crc, i_frames.computed_crc);
            compare_field("received_crc", want.received_crc, i_frames.received_crc);
            compare_field("frame_payload_length", want.pay_length,
                          i_frames.frame_payload_length);
        end
    endtask

    // A result always belongs to a byte taken at an earlier edge, so it is
    // checked before the byte of the same edge is parsed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos    = '0;
            in_frame     = 1'b0;
            frame_len    = '0;
            crc_in_frame = '0;
            crc_acc      = '0;
        end else begin
            if (i_frames.valid && i_frames.ready) begin
                check_frame_result();
            end
            if (i_bytes.valid && i_bytes.ready) begin
                parse_byte(i_bytes.rx_byte, i_bytes.frame_start);
            end
        end
        o_pending = expected_frames.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame CRC checker testbench
// Sends directed and random byte streams (well-formed frames, bad sync pairs,
// cut-off frames and stray bytes) under several idle and stall patterns, and
// gives the verdict from the failure count of the frame checker.
// ----------------------------------------------------------------------------
module tb;
    import sfcc_pkg::*;

    localparam int PHASE_ITEMS      = 175;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 20;
    localparam int TIMEOUT_NS       = 1_000_000;

    logic clk = 1'b0;
    logic rst_n;

    sfcc_in_if  in_ch ();
    sfcc_out_if res_ch ();

    int   fail_count;
    int   pend_count;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    int   frame_items  = 0;
    logic long_hold    = 1'b0;
    logic hold_taken;

    sensor_frame_crc_checker dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    sfcc_frame_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_bytes      (in_ch),
        .i_frames     (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pend_count)
    );

    always #1 clk = ~clk;

    initial begin
        #(TIMEOUT_NS);
        $display("[sensor_frame_crc_checker] ERROR");
        $finish;
    end

    // Result receiver. A long hold is counted here so that the sender keeps
    // offering bytes while the block backs up.
    initial begin
        hold_taken   = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold && !hold_taken) begin
                res_ch.ready <= 1'b0;
                for (int k = 1; k < LONG_HOLD_CYCLES; k++) begin
                    @(negedge clk);
                end
                hold_taken = 1'b1;
            end else begin
                if (!long_hold) hold_taken = 1'b0;
                res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic send_byte(input t_byte b, input logic start);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge clk);
            in_ch.valid       <= 1'b0;
            in_ch.rx_byte     <= t_byte'($urandom);
            in_ch.frame_start <= 1'($urandom);
        end
        @(negedge clk);
        in_ch.valid       <= 1'b1;
        in_ch.rx_byte     <= b;
        in_ch.frame_start <= start;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // Sends a frame with a random payload. A nonzero keep cuts it off after
    // that many bytes; a corrupt frame carries a wrong CRC.
    task automatic send_frame(input t_word len, input bit corrupt, input int keep);
        t_byte frm[$];
        t_byte pay[$];
        t_word crc;
        int    pay_n;
        int    total;
        pay_n = (keep > 0) ? ((keep > 6) ? keep - 6 : 0) : int'(len);
        for (int i = 0; i < pay_n; i++) pay.push_back(t_byte'($urandom));
        frm = '{SYNC0_CODE, SYNC1_CODE, len[7:0], len[15:8]};
        crc = '0;
        foreach (frm[i]) crc = chk.crc_step(crc, frm[i]);
        foreach (pay[i]) crc = chk.crc_step(crc, pay[i]);
        if (corrupt) crc = crc ^ t_word'($urandom_range(1, 65535));
        frm.push_back(crc[7:0]);
        frm.push_back(crc[15:8]);
        foreach (pay[i]) frm.push_back(pay[i]);
        total = (keep > 0 && keep < frm.size()) ? keep : frm.size();
        for (int i = 0; i < total; i++) send_byte(frm[i], i == 0);
        if (keep == 0) frame_items += total;
    endtask

    function automatic t_word random_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85) return t_word'($urandom_range(0, 12));
        if (roll < 98) return t_word'($urandom_range(13, 64));
        return t_word'($urandom_range(200, 600));
    endfunction

    task automatic random_burst();
        int    roll;
        t_word len;
        t_byte b0;
        t_byte b1;
        roll = $urandom_range(99);
        if (roll < 70) begin
            send_frame(random_len(), $urandom_range(99) < 30, 0);
            if ($urandom_range(4) == 0) send_byte(t_byte'($urandom), 1'b0);
        end else if (roll < 78) begin
            len = t_word'($urandom_range(0, 12));
            send_frame(len, 1'b0, $urandom_range(1, 5 + int'(len)));
        end else if (roll < 86) begin
            b0 = SYNC0_CODE;
            b1 = SYNC1_CODE;
            if ($urandom_range(1) == 0) begin
                b0 = t_byte'($urandom);
                if (b0 == SYNC0_CODE) b0 = ~b0;
            end else begin
                b1 = t_byte'($urandom);
                if (b1 == SYNC1_CODE) b1 = ~b1;
            end
            send_byte(b0, 1'b1);
            send_byte(b1, 1'b0);
            repeat ($urandom_range(0, 3)) send_byte(t_byte'($urandom), 1'b0);
        end else begin
            repeat ($urandom_range(1, 4)) begin
                send_byte(t_byte'($urandom), $urandom_range(3) == 0);
            end
        end
    endtask

    initial begin
        int target;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.rx_byte     = '0;
        in_ch.frame_start = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: stray byte before any frame, zero length, bad sync pairs,
        // a maximum-length frame cut short by a new start, a wrong CRC and a
        // byte after the frame end.
        send_byte(8'h00, 1'b0);
        send_frame(16'h0000, 1'b0, 0);
        send_byte(SYNC0_CODE, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(SYNC1_CODE, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_frame(16'hFFFF, 1'b0, 4);
        send_frame(16'h0001, 1'b1, 0);
        send_byte(8'hFF, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
                default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
            endcase
            target = frame_items + PHASE_ITEMS;
            if (ph == 0) begin
                // The receiver holds off while short frames keep coming, so
                // the block fills up and stops taking bytes.
                long_hold = 1'b1;
                repeat (6) send_frame(t_word'($urandom_range(0, 3)), 1'b0, 0);
                long_hold = 1'b0;
            end
            while (frame_items < target) random_burst();
            // Let every pending result drain before the next pattern.
            @(negedge clk);
            in_ch.valid <= 1'b0;
            wait (pend_count == 0);
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end

        rx_stall_pct = 0;
        wait (pend_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pend_count == 0) begin
            $display("[sensor_frame_crc_checker] OK");
        end else begin
            $display("[sensor_frame_crc_checker] ERROR");
        end
        $finish;
    end

endmodule
